// ----- design/i2da_pkg.sv -----
// ----------------------------------------------------------------------------
// i2da_pkg
// Shared types and constants for the integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
package i2da_pkg;

  // Fixed field widths of the channels
  localparam int unsigned VALUE_BITS_W = 64;
  localparam int unsigned CHAR_W       = 8;

  // ASCII codes
  localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;

  // Control passed from the converter to the text emitter
  typedef struct packed {
    logic valid;
    logic neg;
  } handoff_ctl_t;

endpackage

// ----- design/i2da_if.sv -----
// ----------------------------------------------------------------------------
// i2da_if
// Valid/ready channels of the integer to decimal ASCII unit.
// ----------------------------------------------------------------------------
interface i2da_req_if import i2da_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [VALUE_BITS_W-1:0] value_bits;
  logic                    is_signed;

  modport source (output valid, output value_bits, output is_signed, input ready);
  modport sink   (input valid, input value_bits, input is_signed, output ready);
endinterface

interface i2da_txt_if import i2da_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [CHAR_W-1:0] char_code;
  logic              last_char;

  modport source (output valid, output char_code, output last_char, input ready);
  modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

// ----- design/i2da_dabble.sv -----
// ----------------------------------------------------------------------------
// i2da_dabble
// Bit-serial double dabble: shifts the magnitude into a BCD register one bit
// per cycle, with add-3 correction on every digit.
// ----------------------------------------------------------------------------
module i2da_dabble import i2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned NDIG        = 20
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [VALUE_WIDTH-1:0]  value,
  input  logic                    is_signed,
  output handoff_ctl_t            ctl,
  input  logic                    ctl_ready,
  output logic [4*NDIG-1:0]       bcd
);

  localparam int unsigned CW = $clog2(VALUE_WIDTH + 1);

  logic                   busy;
  logic                   done;
  logic [CW-1:0]          count;
  logic [VALUE_WIDTH-1:0] mag;
  logic                   neg;
  logic [4*NDIG-1:0]      bcd_adj;
  logic                   in_neg;

  assign in_ready = !busy && !done;
  assign in_neg   = is_signed && value[VALUE_WIDTH-1];

  // Add 3 to every digit of five or more before the shift
  always_comb begin
    for (int d = 0; d < NDIG; d++) begin
      if (bcd[4*d +: 4] >= 4'd5) begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4] + 4'd3;
      end else begin
        bcd_adj[4*d +: 4] = bcd[4*d +: 4];
      end
    end
  end

  // Load, shift one bit per cycle, then hold until the emitter takes it
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      if (in_valid && in_ready) begin
        busy  <= 1'b1;
        count <= CW'(VALUE_WIDTH);
        neg   <= in_neg;
        mag   <= in_neg ? (~value + VALUE_WIDTH'(1)) : value;
        bcd   <= '0;
      end else if (busy) begin
        {bcd, mag} <= {bcd_adj[4*NDIG-2:0], mag, 1'b0};
        count      <= count - CW'(1);
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end else if (done && ctl_ready) begin
        done <= 1'b0;
      end
    end
  end

  assign ctl.valid = done;
  assign ctl.neg   = neg;

endmodule

// ----- design/i2da_emit.sv -----
// ----------------------------------------------------------------------------
// i2da_emit
// Text emitter: skips leading zero digits, then sends any minus sign and the
// digits most significant first through an output register.
// ----------------------------------------------------------------------------
module i2da_emit import i2da_pkg::*; #(
  parameter int unsigned NDIG      = 20,
  parameter int unsigned MAX_CHARS = 20
) (
  input  logic              clk,
  input  logic              rst,
  input  handoff_ctl_t      ctl,
  output logic              ctl_ready,
  input  logic [4*NDIG-1:0] bcd_in,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [CHAR_W-1:0] char_code,
  output logic              last_char
);

  localparam int unsigned RW = $clog2(NDIG + 1);
  localparam int unsigned EW = $clog2(MAX_CHARS + 1);

  typedef enum logic [1:0] {IDLE, SKIP, SIGN, DIGIT} state_t;

  state_t            state;
  logic [4*NDIG-1:0] bcd;
  logic              neg;
  logic [RW-1:0]     remaining;
  logic [EW-1:0]     emitted;
  logic [3:0]        top;
  logic              load_ok;
  logic              emit_now;
  logic              is_last;

  assign ctl_ready = (state == IDLE);
  assign top       = bcd[4*NDIG-1 -: 4];
  assign load_ok   = !out_valid || out_ready;
  assign emit_now  = load_ok && ((state == SIGN) || (state == DIGIT));
  assign is_last   = (remaining == RW'(1)) || (emitted == EW'(MAX_CHARS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= IDLE;
      out_valid <= 1'b0;
    end else begin
      // Drop the output item once taken, unless a new one replaces it
      if (out_ready && !emit_now) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (ctl.valid) begin
            bcd       <= bcd_in;
            neg       <= ctl.neg;
            remaining <= RW'(NDIG);
            emitted   <= '0;
            state     <= SKIP;
          end
        end
        // Advance past leading zeros, keeping at least one digit
        SKIP: begin
          if (top == 4'd0 && remaining != RW'(1)) begin
            bcd       <= {bcd[4*NDIG-5:0], 4'd0};
            remaining <= remaining - RW'(1);
          end else begin
            state <= neg ? SIGN : DIGIT;
          end
        end
        SIGN: begin
          if (load_ok) begin
            out_valid <= 1'b1;
            char_code <= CHAR_MINUS;
            last_char <= 1'b0;
            emitted   <= emitted + EW'(1);
            state     <= DIGIT;
          end
        end
        DIGIT: begin
          if (load_ok) begin
            out_valid <= 1'b1;
            char_code <= CHAR_ZERO + {4'd0, top};
            last_char <= is_last;
            bcd       <= {bcd[4*NDIG-5:0], 4'd0};
            remaining <= remaining - RW'(1);
            emitted   <= emitted + EW'(1);
            if (is_last) begin
              state <= IDLE;
            end
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

// ----- design/integer_to_decimal_ascii_unit.sv -----
// ----------------------------------------------------------------------------
// integer_to_decimal_ascii_unit
// Converts a signed or unsigned integer into decimal ASCII text, one
// character per output item, most significant first.
//
// Channel | Dir | Payload                  | Item
// req     | in  | value_bits, is_signed    | one number
// txt     | out | char_code, last_char     | one character
//
// A number is loaded, shifted through the bit-serial double dabble loop
// and handed off; the emitter then skips leading zeros and sends the
// characters.
// A new number may enter the converter while the previous text is emitted.
// Reset (rst, synchronous) clears the control state only.
// A stall on txt holds the output item and pauses the emitter.
// ----------------------------------------------------------------------------
module integer_to_decimal_ascii_unit import i2da_pkg::*; #(
  parameter int unsigned VALUE_WIDTH = 64,
  parameter int unsigned MAX_CHARS   = 20
) (
  input  logic       clk,
  input  logic       rst,
  i2da_req_if.sink   req,
  i2da_txt_if.source txt
);

  // Decimal digits of the largest unsigned value
  localparam int unsigned NDIG = (VALUE_WIDTH * 30103) / 100000 + 1;

  handoff_ctl_t      ctl;
  logic              ctl_ready;
  logic [4*NDIG-1:0] bcd;

  i2da_dabble #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dabble (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (req.valid),
    .in_ready  (req.ready),
    .value     (req.value_bits[VALUE_WIDTH-1:0]),
    .is_signed (req.is_signed),
    .ctl       (ctl),
    .ctl_ready (ctl_ready),
    .bcd       (bcd)
  );

  i2da_emit #(
    .NDIG      (NDIG),
    .MAX_CHARS (MAX_CHARS)
  ) u_emit (
    .clk       (clk),
    .rst       (rst),
    .ctl       (ctl),
    .ctl_ready (ctl_ready),
    .bcd_in    (bcd),
    .out_valid (txt.valid),
    .out_ready (txt.ready),
    .char_code (txt.char_code),
    .last_char (txt.last_char)
  );

endmodule

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for integer_to_decimal_ascii_unit. Numbers go in on
// the req channel and are turned into expected character items when they
// are accepted. Every character that leaves on txt is checked against the
// oldest expected item. Both channels idle in random bursts, except in the
// closing back-to-back phase.
// ----------------------------------------------------------------------------
module tb_top;
  import i2da_pkg::*;

  localparam int unsigned WIDTH        = 64;
  localparam int unsigned MAXC         = 20;
  localparam int unsigned TEXT_SLOTS   = 24;
  localparam int unsigned DRAIN_CYCLES = 1 + WIDTH + 2 * MAXC + 8;
  localparam int unsigned STALL_LIMIT  = 5000;
  localparam int unsigned REPORT_MAX   = 10;

  typedef struct packed {
    logic [CHAR_W-1:0] code;
    logic              last;
  } char_item_t;

  logic clk;
  logic rst;

  i2da_req_if req_ch ();
  i2da_txt_if txt_ch ();

  integer_to_decimal_ascii_unit #(
    .VALUE_WIDTH (WIDTH),
    .MAX_CHARS   (MAXC)
  ) dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .txt (txt_ch)
  );

  char_item_t  expected_chars[$];
  int unsigned numbers_sent;
  int unsigned negatives_sent;
  int unsigned chars_checked;
  int unsigned error_count;
  int unsigned quiet_cycles;
  int unsigned stall_left;
  bit          idle_en;

  // Clock
  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Work out the text of one number and queue its characters
  function automatic void queue_decimal_text(input logic [VALUE_BITS_W-1:0] raw,
                                             input logic sgn);
    logic [63:0]       mask;
    logic [63:0]       mag;
    logic              neg;
    logic [CHAR_W-1:0] text [TEXT_SLOTS];
    int unsigned       pos;
    int unsigned       len;
    char_item_t        item;
    mask = {64{1'b1}} >> (64 - WIDTH);
    mag  = raw & mask;
    neg  = sgn && mag[WIDTH-1];
    if (neg) begin
      mag = (64'd0 - mag) & mask;
    end
    pos = TEXT_SLOTS;
    do begin
      pos--;
      text[pos] = CHAR_ZERO + CHAR_W'(mag % 64'd10);
      mag       = mag / 64'd10;
    end while (mag != 64'd0 && pos > 1);
    if (neg) begin
      pos--;
      text[pos] = CHAR_MINUS;
    end
    len = TEXT_SLOTS - pos;
    if (len > MAXC) begin
      len = MAXC;
    end
    for (int unsigned k = 0; k < len; k++) begin
      item.code = text[pos + k];
      item.last = (k + 1 == len);
      expected_chars.push_back(item);
    end
  endfunction

  // Offer one number, hold it until accepted, then queue its text
  task automatic send_number(input logic [VALUE_BITS_W-1:0] raw, input logic sgn);
    int unsigned gap;
    if (idle_en && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 9);
      req_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    req_ch.valid      = 1'b1;
    req_ch.value_bits = raw;
    req_ch.is_signed  = sgn;
    do @(posedge clk); while (req_ch.ready !== 1'b1);
    queue_decimal_text(raw, sgn);
    numbers_sent++;
    if (sgn && raw[WIDTH-1]) begin
      negatives_sent++;
    end
    @(negedge clk);
  endtask

  // Drop valid and wait until every queued character has come out
  task automatic wait_drained();
    req_ch.valid = 1'b0;
    while (expected_chars.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Random value of random magnitude, sometimes negated
  function automatic logic [VALUE_BITS_W-1:0] random_value();
    logic [VALUE_BITS_W-1:0] v;
    v = {$urandom(), $urandom()};
    v = v >> $urandom_range(0, 63);
    if ($urandom_range(0, 1) == 1) begin
      v = -v;
    end
    return v;
  endfunction

  // Extremes, digit-count boundaries and the most negative value
  task automatic test_directed_extremes();
    send_number(64'd0, 1'b0);
    send_number(64'd0, 1'b1);
    send_number(64'd1, 1'b0);
    send_number(64'd9, 1'b1);
    send_number(64'd10, 1'b0);
    send_number(64'd99, 1'b1);
    send_number(64'd100, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'hFFFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b1);
    send_number(64'h8000_0000_0000_0000, 1'b0);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b1);
    send_number(64'h7FFF_FFFF_FFFF_FFFF, 1'b0);
    send_number(64'd9999999999999999999, 1'b0);
    send_number(64'd10000000000000000000, 1'b0);
    send_number(64'd1000000000000000000, 1'b1);
    send_number(-64'd10, 1'b1);
    send_number(-64'd9, 1'b1);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    send_number(64'h5555_5555_5555_5555, 1'b0);
    send_number(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
  endtask

  // Random numbers with idling on both sides and a full drain halfway
  task automatic test_random_mixed();
    for (int i = 0; i < 300; i++) begin
      send_number(random_value(), 1'($urandom_range(0, 1)));
      if (i == 150) begin
        wait_drained();
      end
    end
  endtask

  // Closing phase: no idling on either side
  task automatic test_back_to_back();
    wait_drained();
    idle_en = 1'b0;
    for (int i = 0; i < 80; i++) begin
      send_number(random_value(), 1'($urandom_range(0, 1)));
    end
  endtask

  // Receiver: stall in random bursts while idling is enabled
  always @(negedge clk) begin
    if (stall_left != 0) begin
      stall_left--;
      txt_ch.ready <= 1'b0;
    end else if (idle_en && $urandom_range(0, 15) == 0) begin
      stall_left   = $urandom_range(1, 9) - 1;
      txt_ch.ready <= 1'b0;
    end else begin
      txt_ch.ready <= 1'b1;
    end
  end

  // Check each character against the oldest expected one
  always @(posedge clk) begin
    char_item_t want;
    if (!rst && txt_ch.valid === 1'b1 && txt_ch.ready === 1'b1) begin
      if (expected_chars.size() == 0) begin
        error_count++;
        if (error_count <= REPORT_MAX) begin
          $display("[%0t] unexpected character: code=%0d last=%0b",
                   $realtime, txt_ch.char_code, txt_ch.last_char);
        end
      end else begin
        want = expected_chars.pop_front();
        chars_checked++;
        if (txt_ch.char_code !== want.code || txt_ch.last_char !== want.last) begin
          error_count++;
          if (error_count <= REPORT_MAX) begin
            $display("[%0t] character mismatch: expected code=%0d last=%0b, got code=%0d last=%0b",
                     $realtime, want.code, want.last, txt_ch.char_code, txt_ch.last_char);
          end
        end
      end
    end
  end

  // Watchdog on cycles in which neither channel moves an item
  always @(posedge clk) begin
    if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
        (txt_ch.valid === 1'b1 && txt_ch.ready === 1'b1)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("[%0t] no handshake for %0d cycles", $realtime, STALL_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Sequence the tests
  initial begin
    rst               = 1'b1;
    req_ch.valid      = 1'b0;
    req_ch.value_bits = '0;
    req_ch.is_signed  = 1'b0;
    txt_ch.ready      = 1'b0;
    stall_left        = 0;
    quiet_cycles      = 0;
    numbers_sent      = 0;
    negatives_sent    = 0;
    chars_checked     = 0;
    error_count       = 0;
    idle_en           = 1'b1;
    repeat (7) @(negedge clk);
    rst = 1'b0;

    test_directed_extremes();
    test_random_mixed();
    test_back_to_back();
    wait_drained();

    if (expected_chars.size() != 0) begin
      error_count++;
      $display("%0d expected characters never arrived", expected_chars.size());
    end
    $display("Converted %0d numbers (%0d negative), checked %0d characters, %0d errors.",
             numbers_sent, negatives_sent, chars_checked, error_count);
    $display("Covered range extremes, digit-count boundaries, random magnitudes and stalls.");
    if (error_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
design/i2da_pkg.sv
design/i2da_if.sv
design/i2da_dabble.sv
design/i2da_emit.sv
design/integer_to_decimal_ascii_unit.sv
tb/tb_top.sv
